[hw/rtl/bra_pkg.sv]
`default_nettype none

package bra_pkg;

    localparam int MAP_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int ORDER_W = 4;
    localparam int POS_W   = 10;
    localparam int START_W = 10;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // per-word evaluation qualifiers
    typedef struct packed {
        logic first;
        logic last;
        logic narrow;
    } scan_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/bra_map_mem.sv]
`default_nettype none

module bra_map_mem
    import bra_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int DEPTH     = MAP_BITS_DEF / WORD_BITS_DEF,
    parameter int AW        = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/bra_word_scan.sv]
`default_nettype none

module bra_word_scan
    import bra_pkg::*;
#(
    parameter int MAP_BITS  = MAP_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic [WORD_BITS-1:0]                 word,
    input  wire logic [((($clog2(MAP_BITS) > $clog2(WORD_BITS)) ?
                        ($clog2(MAP_BITS) - $clog2(WORD_BITS)) : 1))-1:0] ev_addr,
    input  wire logic [ORDER_W-1:0]                   order,
    input  wire logic [$clog2(WORD_BITS)-1:0]         b0,
    input  wire logic [((($clog2(MAP_BITS) > $clog2(WORD_BITS)) ?
                        ($clog2(MAP_BITS) - $clog2(WORD_BITS)) : 1))-1:0] wmask,
    input  wire scan_ctl_t                            ctl,
    input  wire logic                                 clean_in,
    output logic                                      hit,
    output logic                                      clean_out,
    output logic [$clog2(MAP_BITS)-1:0]               hit_pos
);

    localparam int LM = $clog2(MAP_BITS);
    localparam int LW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] z [LW+1];
    logic [WORD_BITS-1:0] zsel;
    logic [WORD_BITS-1:0] cand;
    logic [LW-1:0]        amask;
    logic [LW-1:0]        idx;
    logic                 any;
    logic                 is_first;
    logic                 is_last;
    logic                 hit_large;

    // free flags per group of 2^k bits at each start bit, one level per order
    always_comb begin
        z[0] = ~word;
        for (int k = 1; k <= LW; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i + (1 << (k - 1)) < WORD_BITS) begin
                    z[k][i] = z[k-1][i] & z[k-1][i + (1 << (k - 1))];
                end else begin
                    z[k][i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        zsel  = '0;
        amask = '0;
        for (int k = 0; k <= LW; k++) begin
            if (int'(order) == k) begin
                zsel  = z[k];
                amask = LW'((1 << k) - 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            cand[i] = zsel[i] && ((LW'(i) & amask) == '0)
                      && !(ctl.first && (LW'(i) < b0))
                      && !(ctl.last && (LW'(i) >= b0));
        end
    end

    always_comb begin
        idx = '0;
        any = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                idx = LW'(i);
                any = 1'b1;
            end
        end
    end

    // multi-word regions
    assign is_first  = ((ev_addr & wmask) == '0);
    assign is_last   = ((ev_addr & wmask) == wmask);
    assign clean_out = (is_first | clean_in) & ~(|word);
    assign hit_large = is_last & clean_out;

    always_comb begin
        if (ctl.narrow) begin
            hit     = any;
            hit_pos = (LM'(ev_addr) << LW) | LM'(idx);
        end else begin
            hit     = hit_large;
            hit_pos = LM'(ev_addr & ~wmask) << LW;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bitmap_region_allocator_top.sv]
`default_nettype none

// Allocate: a region within one word is found by a scan of the bitmap (one bitmap
// word read and tested per cycle), followed by one write-back.
// A region of W words is found by the same scan and then written one word per cycle.
// Release: a read and a write-back for regions within a word, one write per word otherwise.
// One transaction in flight; the next is taken once the result has been delivered.
// Reset (aresetn low, synchronous) starts a clearing pass over all MAP_WORDS words.
module bitmap_region_allocator_top
    import bra_pkg::*;
#(
    parameter int MAP_BITS  = MAP_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic [ORDER_W-1:0] s_order,
    input  wire logic [POS_W-1:0]   s_position,
    input  wire logic [START_W-1:0] s_start_region,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_found,
    output logic [POS_W-1:0]        m_region_position
);

    localparam int LM        = $clog2(MAP_BITS);
    localparam int LW        = $clog2(WORD_BITS);
    localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
    localparam int WA        = (LM > LW) ? (LM - LW) : 1;
    localparam int CW        = $clog2(MAP_WORDS + 2);
    localparam int PW        = ((LM > POS_W) ? LM : POS_W) + 2;
    localparam logic [WA-1:0] WA_MASK = WA'(MAP_WORDS - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_RDREL = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    function automatic logic [WA-1:0] words_mask(input logic [ORDER_W-1:0] ord);
        int sh;
        sh = int'(ord) - LW;
        if (sh <= 0) begin
            return '0;
        end
        return WA'((64'd1 << sh) - 64'd1);
    endfunction

    state_t               state_reg,   state_next;
    logic                 ev_vld_reg,  ev_vld_next;
    logic [WA-1:0]        wr_addr_reg, wr_addr_next;
    logic                 rel_reg,     rel_next;
    logic [ORDER_W-1:0]   order_reg,   order_next;
    logic                 small_reg,   small_next;
    logic [LW-1:0]        b0_reg,      b0_next;
    logic [WA-1:0]        addr_reg,    addr_next;
    logic [CW-1:0]        iss_cnt_reg, iss_cnt_next;
    logic [WA-1:0]        ev_addr_reg, ev_addr_next;
    logic                 ev_first_reg, ev_first_next;
    logic                 ev_last_reg, ev_last_next;
    logic                 clean_reg,   clean_next;
    logic [WORD_BITS-1:0] word_reg,    word_next;
    logic [LW-1:0]        bit_off_reg, bit_off_next;
    logic [WA-1:0]        wr_cnt_reg,  wr_cnt_next;
    logic                 found_reg,   found_next;
    logic [POS_W-1:0]     pos_reg,     pos_next;

    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WA-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] rd_data;

    logic                 order_ok;
    logic                 in_small;
    logic [LM-1:0]        pos0;
    logic [PW-1:0]        rel_size;
    logic [PW-1:0]        rel_base;
    logic                 rel_fits;
    logic [WA-1:0]        wmask_cur;
    logic                 issuing;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] wr_src;

    scan_ctl_t            sc_ctl;
    logic                 sc_hit;
    logic                 sc_clean;
    logic [LM-1:0]        sc_pos;

    bra_map_mem #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (MAP_WORDS),
        .AW        (WA)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_addr_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    assign sc_ctl = '{first: ev_first_reg, last: ev_last_reg, narrow: small_reg};

    bra_word_scan #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word      (rd_data),
        .ev_addr   (ev_addr_reg),
        .order     (order_reg),
        .b0        (b0_reg),
        .wmask     (wmask_cur),
        .ctl       (sc_ctl),
        .clean_in  (clean_reg),
        .hit       (sc_hit),
        .clean_out (sc_clean),
        .hit_pos   (sc_pos)
    );

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = (state_reg == ST_DONE);
    assign m_found           = found_reg;
    assign m_region_position = pos_reg;

    assign order_ok  = (int'(s_order) <= LM);
    assign in_small  = (int'(s_order) <= LW);
    assign pos0      = LM'(s_start_region) << s_order;
    assign rel_size  = PW'(1) << s_order;
    assign rel_base  = PW'(s_position) & ~(rel_size - PW'(1));
    assign rel_fits  = (rel_base + rel_size) <= PW'(MAP_BITS);
    assign wmask_cur = words_mask(order_reg);
    assign issuing   = (int'(iss_cnt_reg) <= MAP_WORDS);
    assign mem_raddr = (state_reg == ST_SCAN) ? addr_reg : wr_addr_reg;

    assign fill_mask = ~({WORD_BITS{1'b1}} << (1 << order_reg)) << bit_off_reg;
    assign wr_src    = rel_reg ? rd_data : word_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (state_reg == ST_WRITE) begin
            mem_we = 1'b1;
            if (!small_reg) begin
                mem_wdata = {WORD_BITS{~rel_reg}};
            end else if (rel_reg) begin
                mem_wdata = wr_src & ~fill_mask;
            end else begin
                mem_wdata = wr_src | fill_mask;
            end
        end else if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ev_vld_next   = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rel_next      = rel_reg;
        order_next    = order_reg;
        small_next    = small_reg;
        b0_next       = b0_reg;
        addr_next     = addr_reg;
        iss_cnt_next  = iss_cnt_reg;
        ev_addr_next  = addr_reg;
        ev_first_next = 1'b0;
        ev_last_next  = 1'b0;
        clean_next    = clean_reg;
        word_next     = word_reg;
        bit_off_next  = bit_off_reg;
        wr_cnt_next   = wr_cnt_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;

        case (state_reg)
            ST_CLEAR: begin
                wr_addr_next = (wr_addr_reg + WA'(1)) & WA_MASK;
                if (wr_addr_reg == WA_MASK) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    rel_next   = (s_kind == KIND_RELEASE);
                    order_next = s_order;
                    small_next = in_small;
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (!order_ok) begin
                        state_next = ST_DONE;
                    end else if (s_kind == KIND_ALLOC) begin
                        addr_next    = WA'(pos0 >> LW) & WA_MASK;
                        b0_next      = LW'(pos0);
                        iss_cnt_next = '0;
                        clean_next   = 1'b0;
                        state_next   = ST_SCAN;
                    end else if (rel_fits) begin
                        found_next   = 1'b1;
                        pos_next     = POS_W'(rel_base);
                        wr_addr_next = WA'(rel_base >> LW) & WA_MASK;
                        bit_off_next = LW'(rel_base);
                        wr_cnt_next  = words_mask(s_order);
                        state_next   = in_small ? ST_RDREL : ST_WRITE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (issuing) begin
                    addr_next    = (addr_reg + WA'(1)) & WA_MASK;
                    iss_cnt_next = iss_cnt_reg + CW'(1);
                end
                ev_vld_next   = issuing;
                ev_first_next = (iss_cnt_reg == '0);
                ev_last_next  = (int'(iss_cnt_reg) == MAP_WORDS);
                if (ev_vld_reg) begin
                    clean_next = sc_clean;
                    if (sc_hit) begin
                        ev_vld_next  = 1'b0;
                        found_next   = 1'b1;
                        pos_next     = POS_W'(sc_pos);
                        word_next    = rd_data;
                        bit_off_next = LW'(sc_pos);
                        wr_addr_next = WA'(sc_pos >> LW) & WA_MASK;
                        wr_cnt_next  = wmask_cur;
                        state_next   = ST_WRITE;
                    end else if (ev_last_reg) begin
                        ev_vld_next = 1'b0;
                        found_next  = 1'b0;
                        pos_next    = '0;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_RDREL: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (wr_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    wr_cnt_next  = wr_cnt_reg - WA'(1);
                    wr_addr_next = (wr_addr_reg + WA'(1)) & WA_MASK;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ev_vld_reg  <= 1'b0;
            wr_addr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ev_vld_reg  <= ev_vld_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        rel_reg      <= rel_next;
        order_reg    <= order_next;
        small_reg    <= small_next;
        b0_reg       <= b0_next;
        addr_reg     <= addr_next;
        iss_cnt_reg  <= iss_cnt_next;
        ev_addr_reg  <= ev_addr_next;
        ev_first_reg <= ev_first_next;
        ev_last_reg  <= ev_last_next;
        clean_reg    <= clean_next;
        word_reg     <= word_next;
        bit_off_reg  <= bit_off_next;
        wr_cnt_reg   <= wr_cnt_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
    end

endmodule

`default_nettype wire
